// ===== rtl/tmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmrc_pkg
// Shared types and constants for the tank mode and relay controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tmrc_pkg;

  // Field widths
  localparam int unsigned CNT_W    = 20;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned SP_W     = 14;
  localparam int unsigned OFS_W    = 10;
  localparam int unsigned PRES_W   = 12;
  localparam int unsigned PIX_W    = 9;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REG_IDX_W = 3;

  // Event codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_TARGET_TEMP    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEATER_OFFSET  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXIT_MIN_TEMP  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CONFIRM_LIMIT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OVERRIDE_LIMIT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SLEEP_LIMIT    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PRESSURE   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_DEADBAND  = 3'd7;

  // Register reset values
  localparam logic [SP_W-1:0]   RST_TARGET_TEMP    = 14'd7800;
  localparam logic [OFS_W-1:0]  RST_HEATER_OFFSET  = 10'd30;
  localparam logic [SP_W-1:0]   RST_EXIT_MIN_TEMP  = 14'd7400;
  localparam logic [CNT_W-1:0]  RST_CONFIRM_LIMIT  = 20'd2000;
  localparam logic [CNT_W-1:0]  RST_OVERRIDE_LIMIT = 20'd300000;
  localparam logic [CNT_W-1:0]  RST_SLEEP_LIMIT    = 20'd300000;
  localparam logic [PRES_W-1:0] RST_MIN_PRESSURE   = 12'd100;
  localparam logic [OFS_W-1:0]  RST_TEMP_DEADBAND  = 10'd5;

  // Temperature limits and reset temperature (hundredths of a degree F)
  localparam logic signed [TEMP_W-1:0] TEMP_LOW   = 16'sd3200;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH  = 16'sd12000;
  localparam logic signed [TEMP_W-1:0] TEMP_RESET = 16'sd7400;

  // Saturation value of the tick counters
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Maintenance button box, inclusive bounds
  localparam logic [PIX_W-1:0] MNT_X_LO = 9'd283;
  localparam logic [PIX_W-1:0] MNT_X_HI = 9'd472;
  localparam logic [PIX_W-1:0] MNT_Y_LO = 9'd5;
  localparam logic [PIX_W-1:0] MNT_Y_HI = 9'd34;

  // Lights panel box, inclusive bounds
  localparam logic [PIX_W-1:0] PNL_X_LO = 9'd240;
  localparam logic [PIX_W-1:0] PNL_X_HI = 9'd479;
  localparam logic [PIX_W-1:0] PNL_Y_LO = 9'd40;
  localparam logic [PIX_W-1:0] PNL_Y_HI = 9'd279;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_CONFIRM = 2'd1,
    MODE_ACTIVE  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [SP_W-1:0]   target_temp;
    logic [OFS_W-1:0]  heater_offset;
    logic [SP_W-1:0]   exit_min_temp;
    logic [CNT_W-1:0]  confirm_limit;
    logic [CNT_W-1:0]  override_limit;
    logic [CNT_W-1:0]  sleep_limit;
    logic [PRES_W-1:0] min_pressure;
    logic [OFS_W-1:0]  temp_deadband;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TEMP_W-1:0] temp_sample;
    logic [PIX_W-1:0]  touch_x;
    logic [PIX_W-1:0]  touch_y;
    logic [PRES_W-1:0] touch_pressure;
  } item_t;

  typedef struct packed {
    logic              heater_on;
    logic              filter_on;
    logic              lights_on;
    logic [1:0]        mode;
    logic              override_active;
    logic              display_asleep;
    logic              exit_refused;
    logic [TEMP_W-1:0] temperature;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/tmrc_if.sv =====
// ----------------------------------------------------------------------------
// tmrc_if
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmrc_in_if;
  logic                               valid;
  logic                               ready;
  logic [tmrc_pkg::CMD_W-1:0]         command;
  logic signed [tmrc_pkg::TEMP_W-1:0] temp_sample;
  logic [tmrc_pkg::PIX_W-1:0]         touch_x;
  logic [tmrc_pkg::PIX_W-1:0]         touch_y;
  logic [tmrc_pkg::PRES_W-1:0]        touch_pressure;

  modport source (
    output valid, command, temp_sample, touch_x, touch_y, touch_pressure,
    input  ready
  );
  modport sink (
    input  valid, command, temp_sample, touch_x, touch_y, touch_pressure,
    output ready
  );
endinterface

interface tmrc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               heater_on;
  logic                               filter_on;
  logic                               lights_on;
  logic [1:0]                         mode;
  logic                               override_active;
  logic                               display_asleep;
  logic                               exit_refused;
  logic signed [tmrc_pkg::TEMP_W-1:0] temperature;

  modport source (
    output valid, heater_on, filter_on, lights_on, mode, override_active,
           display_asleep, exit_refused, temperature,
    input  ready
  );
  modport sink (
    input  valid, heater_on, filter_on, lights_on, mode, override_active,
           display_asleep, exit_refused, temperature,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tmrc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tmrc_cfg_regs
// APB register file holding the eight controller settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrc_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tmrc_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [tmrc_pkg::DATA_W-1:0]     pwdata,
  output logic      [tmrc_pkg::DATA_W-1:0]     prdata,
  output logic                                 pready,
  output tmrc_pkg::cfg_t                       cfg_o
);

  tmrc_pkg::cfg_t                    cfg_q;
  logic [tmrc_pkg::REG_IDX_W-1:0]    idx;
  logic                              wr_en;

  assign idx    = paddr[tmrc_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write the addressed register on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp    <= tmrc_pkg::RST_TARGET_TEMP;
      cfg_q.heater_offset  <= tmrc_pkg::RST_HEATER_OFFSET;
      cfg_q.exit_min_temp  <= tmrc_pkg::RST_EXIT_MIN_TEMP;
      cfg_q.confirm_limit  <= tmrc_pkg::RST_CONFIRM_LIMIT;
      cfg_q.override_limit <= tmrc_pkg::RST_OVERRIDE_LIMIT;
      cfg_q.sleep_limit    <= tmrc_pkg::RST_SLEEP_LIMIT;
      cfg_q.min_pressure   <= tmrc_pkg::RST_MIN_PRESSURE;
      cfg_q.temp_deadband  <= tmrc_pkg::RST_TEMP_DEADBAND;
    end else if (wr_en) begin
      case (idx)
        tmrc_pkg::REG_TARGET_TEMP:    cfg_q.target_temp    <= pwdata[tmrc_pkg::SP_W-1:0];
        tmrc_pkg::REG_HEATER_OFFSET:  cfg_q.heater_offset  <= pwdata[tmrc_pkg::OFS_W-1:0];
        tmrc_pkg::REG_EXIT_MIN_TEMP:  cfg_q.exit_min_temp  <= pwdata[tmrc_pkg::SP_W-1:0];
        tmrc_pkg::REG_CONFIRM_LIMIT:  cfg_q.confirm_limit  <= pwdata[tmrc_pkg::CNT_W-1:0];
        tmrc_pkg::REG_OVERRIDE_LIMIT: cfg_q.override_limit <= pwdata[tmrc_pkg::CNT_W-1:0];
        tmrc_pkg::REG_SLEEP_LIMIT:    cfg_q.sleep_limit    <= pwdata[tmrc_pkg::CNT_W-1:0];
        tmrc_pkg::REG_MIN_PRESSURE:   cfg_q.min_pressure   <= pwdata[tmrc_pkg::PRES_W-1:0];
        tmrc_pkg::REG_TEMP_DEADBAND:  cfg_q.temp_deadband  <= pwdata[tmrc_pkg::OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero extended
  always_comb begin
    prdata = '0;
    case (idx)
      tmrc_pkg::REG_TARGET_TEMP:    prdata[tmrc_pkg::SP_W-1:0]   = cfg_q.target_temp;
      tmrc_pkg::REG_HEATER_OFFSET:  prdata[tmrc_pkg::OFS_W-1:0]  = cfg_q.heater_offset;
      tmrc_pkg::REG_EXIT_MIN_TEMP:  prdata[tmrc_pkg::SP_W-1:0]   = cfg_q.exit_min_temp;
      tmrc_pkg::REG_CONFIRM_LIMIT:  prdata[tmrc_pkg::CNT_W-1:0]  = cfg_q.confirm_limit;
      tmrc_pkg::REG_OVERRIDE_LIMIT: prdata[tmrc_pkg::CNT_W-1:0]  = cfg_q.override_limit;
      tmrc_pkg::REG_SLEEP_LIMIT:    prdata[tmrc_pkg::CNT_W-1:0]  = cfg_q.sleep_limit;
      tmrc_pkg::REG_MIN_PRESSURE:   prdata[tmrc_pkg::PRES_W-1:0] = cfg_q.min_pressure;
      tmrc_pkg::REG_TEMP_DEADBAND:  prdata[tmrc_pkg::OFS_W-1:0]  = cfg_q.temp_deadband;
      default:                      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tmrc_core.sv =====
// ----------------------------------------------------------------------------
// tmrc_core
// Controller state, combinational event update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrc_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tmrc_pkg::cfg_t   cfg_i,
  input  wire logic             item_valid_i,
  input  wire tmrc_pkg::item_t  item_i,
  output logic                  item_ready_o,
  output logic                  res_valid_o,
  output tmrc_pkg::result_t     res_o,
  input  wire logic             res_ready_i
);

  localparam int unsigned DIFF_W = tmrc_pkg::TEMP_W + 1;

  // State
  logic signed [tmrc_pkg::TEMP_W-1:0] temp_q, temp_d;
  tmrc_pkg::mode_e                    mode_q, mode_d;
  logic [tmrc_pkg::CNT_W-1:0]         confirm_cnt_q, confirm_cnt_d;
  logic [tmrc_pkg::CNT_W-1:0]         override_cnt_q, override_cnt_d;
  logic [tmrc_pkg::CNT_W-1:0]         idle_cnt_q, idle_cnt_d;
  logic                               lights_q, lights_d;
  logic                               override_q, override_d;
  logic                               asleep_q, asleep_d;

  // Result register
  logic                               res_valid_q;
  tmrc_pkg::result_t                  res_q, res_d;

  // Datapath
  logic                               advance;
  logic                               refused;
  logic [tmrc_pkg::CNT_W-1:0]         confirm_inc, override_inc, idle_inc;
  logic signed [DIFF_W-1:0]           diff;
  logic [DIFF_W-1:0]                  diff_abs;
  logic                               sample_ok;
  logic                               pressed, in_mnt, in_pnl;
  logic signed [DIFF_W-1:0]           heat_thr;

  assign advance      = item_valid_i && (!res_valid_q || res_ready_i);
  assign item_ready_o = !res_valid_q || res_ready_i;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  // Saturating counter increments
  assign confirm_inc  = (confirm_cnt_q == tmrc_pkg::CNT_MAX) ? tmrc_pkg::CNT_MAX
                                                              : confirm_cnt_q + 1'b1;
  assign override_inc = (override_cnt_q == tmrc_pkg::CNT_MAX) ? tmrc_pkg::CNT_MAX
                                                               : override_cnt_q + 1'b1;
  assign idle_inc     = (idle_cnt_q == tmrc_pkg::CNT_MAX) ? tmrc_pkg::CNT_MAX
                                                           : idle_cnt_q + 1'b1;

  // Sample acceptance: range window and deadband
  assign diff      = $signed({item_i.temp_sample[tmrc_pkg::TEMP_W-1], item_i.temp_sample})
                   - $signed({temp_q[tmrc_pkg::TEMP_W-1], temp_q});
  assign diff_abs  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign sample_ok = ($signed(item_i.temp_sample) > tmrc_pkg::TEMP_LOW)
                  && ($signed(item_i.temp_sample) < tmrc_pkg::TEMP_HIGH)
                  && (diff_abs > DIFF_W'(cfg_i.temp_deadband));

  // Touch qualification and hit boxes
  assign pressed = item_i.touch_pressure >= cfg_i.min_pressure;
  assign in_mnt  = (item_i.touch_x >= tmrc_pkg::MNT_X_LO) && (item_i.touch_x <= tmrc_pkg::MNT_X_HI)
                && (item_i.touch_y >= tmrc_pkg::MNT_Y_LO) && (item_i.touch_y <= tmrc_pkg::MNT_Y_HI);
  assign in_pnl  = (item_i.touch_x >= tmrc_pkg::PNL_X_LO) && (item_i.touch_x <= tmrc_pkg::PNL_X_HI)
                && (item_i.touch_y >= tmrc_pkg::PNL_Y_LO) && (item_i.touch_y <= tmrc_pkg::PNL_Y_HI);

  // Heater threshold: set point minus offset
  assign heat_thr = $signed({3'b000, cfg_i.target_temp}) - $signed({7'd0, cfg_i.heater_offset});

  // Apply one event to the state
  always_comb begin
    temp_d         = temp_q;
    mode_d         = mode_q;
    confirm_cnt_d  = confirm_cnt_q;
    override_cnt_d = override_cnt_q;
    idle_cnt_d     = idle_cnt_q;
    lights_d       = lights_q;
    override_d     = override_q;
    asleep_d       = asleep_q;
    refused        = 1'b0;
    case (item_i.command)
      tmrc_pkg::CMD_TICK: begin
        if (mode_q == tmrc_pkg::MODE_CONFIRM) begin
          confirm_cnt_d = confirm_inc;
          if (confirm_inc >= cfg_i.confirm_limit) mode_d = tmrc_pkg::MODE_NORMAL;
        end
        if (override_q) begin
          override_cnt_d = override_inc;
          if (override_inc >= cfg_i.override_limit) begin
            override_d = 1'b0;
            lights_d   = 1'b0;
          end
        end
        if (!asleep_q) begin
          idle_cnt_d = idle_inc;
          if (idle_inc > cfg_i.sleep_limit) asleep_d = 1'b1;
        end
      end
      tmrc_pkg::CMD_SAMPLE: begin
        if (sample_ok) temp_d = item_i.temp_sample;
      end
      tmrc_pkg::CMD_TOUCH: begin
        if (pressed) begin
          idle_cnt_d = '0;
          if (asleep_q) begin
            // Wake only
            asleep_d = 1'b0;
          end else if (in_mnt) begin
            case (mode_q)
              tmrc_pkg::MODE_NORMAL: begin
                mode_d        = tmrc_pkg::MODE_CONFIRM;
                confirm_cnt_d = '0;
              end
              tmrc_pkg::MODE_CONFIRM: begin
                mode_d   = tmrc_pkg::MODE_ACTIVE;
                lights_d = 1'b1;
              end
              tmrc_pkg::MODE_ACTIVE: begin
                if ($signed({2'b00, temp_q}) >= $signed({4'd0, cfg_i.exit_min_temp}))
                  mode_d = tmrc_pkg::MODE_NORMAL;
                else
                  refused = 1'b1;
              end
              default: ;
            endcase
          end else if (mode_q != tmrc_pkg::MODE_ACTIVE && in_pnl && !lights_q) begin
            override_d     = 1'b1;
            override_cnt_d = '0;
            lights_d       = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Build the result from the updated state
  always_comb begin
    res_d.filter_on       = (mode_d != tmrc_pkg::MODE_ACTIVE);
    res_d.heater_on       = (mode_d != tmrc_pkg::MODE_ACTIVE)
                         && ($signed({temp_d[tmrc_pkg::TEMP_W-1], temp_d}) < heat_thr);
    res_d.lights_on       = lights_d;
    res_d.mode            = mode_d;
    res_d.override_active = override_d;
    res_d.display_asleep  = asleep_d;
    res_d.exit_refused    = refused;
    res_d.temperature     = temp_d;
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q         <= tmrc_pkg::TEMP_RESET;
      mode_q         <= tmrc_pkg::MODE_NORMAL;
      confirm_cnt_q  <= '0;
      override_cnt_q <= '0;
      idle_cnt_q     <= '0;
      lights_q       <= 1'b0;
      override_q     <= 1'b0;
      asleep_q       <= 1'b0;
      res_valid_q    <= 1'b0;
    end else begin
      if (advance) begin
        temp_q         <= temp_d;
        mode_q         <= mode_d;
        confirm_cnt_q  <= confirm_cnt_d;
        override_cnt_q <= override_cnt_d;
        idle_cnt_q     <= idle_cnt_d;
        lights_q       <= lights_d;
        override_q     <= override_d;
        asleep_q       <= asleep_d;
      end
      if (item_ready_o) res_valid_q <= item_valid_i;
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

endmodule

`default_nettype wire

// ===== rtl/tank_mode_and_relay_controller.sv =====
// ----------------------------------------------------------------------------
// tank_mode_and_relay_controller
// Tank temperature, maintenance mode, lights override and display sleep.
// ----------------------------------------------------------------------------
// Takes one event item per clock (tick, temperature sample or touch) while
// the result side does not stall, and returns exactly one result item per
// event, showing the relay drives and state after that event. An item passes
// through an input register and then a result register, which presents its
// result until taken; the state update between those two registers is
// combinational. The input register lets a new item enter while the previous
// result still waits. Settings are to be written over the APB port only
// while no item is in flight; the block itself does not enforce this.
`default_nettype none

module tank_mode_and_relay_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  tmrc_in_if.sink                              in_if,
  tmrc_out_if.source                           out_if,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tmrc_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [tmrc_pkg::DATA_W-1:0]     pwdata,
  output logic      [tmrc_pkg::DATA_W-1:0]     prdata,
  output logic                                 pready
);

  tmrc_pkg::cfg_t    cfg;
  tmrc_pkg::item_t   item_q;
  logic              in_valid_q;
  logic              core_ready;
  logic              res_valid;
  tmrc_pkg::result_t res;

  // Settings
  tmrc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register: refill when empty or whenever the core takes the held item
  assign in_if.ready = !in_valid_q || core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q.command        <= in_if.command;
      item_q.temp_sample    <= in_if.temp_sample;
      item_q.touch_x        <= in_if.touch_x;
      item_q.touch_y        <= in_if.touch_y;
      item_q.touch_pressure <= in_if.touch_pressure;
    end
  end

  // State update and result register
  tmrc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (in_valid_q),
    .item_i       (item_q),
    .item_ready_o (core_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (out_if.ready)
  );

  // Drive the result channel
  assign out_if.valid           = res_valid;
  assign out_if.heater_on       = res.heater_on;
  assign out_if.filter_on       = res.filter_on;
  assign out_if.lights_on       = res.lights_on;
  assign out_if.mode            = res.mode;
  assign out_if.override_active = res.override_active;
  assign out_if.display_asleep  = res.display_asleep;
  assign out_if.exit_refused    = res.exit_refused;
  assign out_if.temperature     = res.temperature;

  // Heater never runs with the filter stopped
  a_heater_needs_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.heater_on |-> out_if.filter_on)
    else $error("heater on while filter off");

  // A refused exit only happens in maintenance
  a_refuse_in_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.exit_refused |-> out_if.mode == tmrc_pkg::MODE_ACTIVE)
    else $error("exit refused outside active mode");

  // A running override keeps the lights on
  a_override_lights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.override_active |-> out_if.lights_on)
    else $error("override running with lights off");

  // An accepted item is held in the input register next cycle
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> in_valid_q)
    else $error("accepted item lost");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tank mode and relay controller.
// ----------------------------------------------------------------------------
// Drives tick, sample, touch and unused-command items through the event channel, with bursts,
// gaps and a stalling result side. A status checker class keeps its own copy
// of the controller state and settings. It predicts the status item for each
// accepted event and compares every returned item field by field. Settings
// are rewritten over APB between phases, once every status item is back.
// The run covers the reset values, a short directed pass over the mode and
// timer corners, and random phases at mid-range, lowest, highest and full-range settings.

module tb_top;
  import tmrc_pkg::*;

  // Command code the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Setting ranges
  localparam int SET_MIN   = 3200;
  localparam int SET_MAX   = 12000;
  localparam int OFS_MAX   = 1000;
  localparam int LIMIT_MAX = 1000000;
  localparam int PRES_MAX  = 4095;

  // --------------------------------------------------------------------------
  // Status predictor and checker
  // --------------------------------------------------------------------------
  class tank_status_checker;
    cfg_t                     cfg;
    logic signed [TEMP_W-1:0] cur_temp;
    mode_e                    mode;
    logic [CNT_W-1:0]         confirm_cnt;
    logic [CNT_W-1:0]         ovr_cnt;
    logic [CNT_W-1:0]         idle_cnt;
    bit                       lights;
    bit                       ovr_run;
    bit                       asleep;
    result_t                  pending_status[$];
    int                       errors;
    int                       checked;
    int                       n_tick;
    int                       n_sample;
    int                       n_touch;
    int                       n_unused;

    function new();
      cfg.target_temp    = RST_TARGET_TEMP;
      cfg.heater_offset  = RST_HEATER_OFFSET;
      cfg.exit_min_temp  = RST_EXIT_MIN_TEMP;
      cfg.confirm_limit  = RST_CONFIRM_LIMIT;
      cfg.override_limit = RST_OVERRIDE_LIMIT;
      cfg.sleep_limit    = RST_SLEEP_LIMIT;
      cfg.min_pressure   = RST_MIN_PRESSURE;
      cfg.temp_deadband  = RST_TEMP_DEADBAND;
      cur_temp    = TEMP_RESET;
      mode        = MODE_NORMAL;
      confirm_cnt = '0;
      ovr_cnt     = '0;
      idle_cnt    = '0;
      lights      = 1'b0;
      ovr_run     = 1'b0;
      asleep      = 1'b0;
      errors      = 0;
      checked     = 0;
      n_tick      = 0;
      n_sample    = 0;
      n_touch     = 0;
      n_unused    = 0;
    endfunction

    // Mirror a register write, truncated to the register width
    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_TARGET_TEMP:    cfg.target_temp    = val[SP_W-1:0];
        REG_HEATER_OFFSET:  cfg.heater_offset  = val[OFS_W-1:0];
        REG_EXIT_MIN_TEMP:  cfg.exit_min_temp  = val[SP_W-1:0];
        REG_CONFIRM_LIMIT:  cfg.confirm_limit  = val[CNT_W-1:0];
        REG_OVERRIDE_LIMIT: cfg.override_limit = val[CNT_W-1:0];
        REG_SLEEP_LIMIT:    cfg.sleep_limit    = val[CNT_W-1:0];
        REG_MIN_PRESSURE:   cfg.min_pressure   = val[PRES_W-1:0];
        REG_TEMP_DEADBAND:  cfg.temp_deadband  = val[OFS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // Advance the state by one event and return the status it leaves
    function result_t predict_status(item_t it);
      result_t r;
      bit      refused;
      bit      in_mnt;
      bit      in_pnl;
      int      smp;
      int      diff;
      int      thr;
      refused = 1'b0;
      case (it.command)
        CMD_TICK: begin
          if (mode == MODE_CONFIRM) begin
            confirm_cnt = bump(confirm_cnt);
            if (confirm_cnt >= cfg.confirm_limit) mode = MODE_NORMAL;
          end
          if (ovr_run) begin
            ovr_cnt = bump(ovr_cnt);
            if (ovr_cnt >= cfg.override_limit) begin
              ovr_run = 1'b0;
              lights  = 1'b0;
            end
          end
          if (!asleep) begin
            idle_cnt = bump(idle_cnt);
            if (idle_cnt > cfg.sleep_limit) asleep = 1'b1;
          end
        end
        CMD_SAMPLE: begin
          smp  = $signed(it.temp_sample);
          diff = smp - int'(cur_temp);
          if (diff < 0) diff = -diff;
          if (smp > int'(TEMP_LOW) && smp < int'(TEMP_HIGH) &&
              diff > int'(cfg.temp_deadband))
            cur_temp = smp[TEMP_W-1:0];
        end
        CMD_TOUCH: begin
          in_mnt = it.touch_x >= MNT_X_LO && it.touch_x <= MNT_X_HI &&
                   it.touch_y >= MNT_Y_LO && it.touch_y <= MNT_Y_HI;
          in_pnl = it.touch_x >= PNL_X_LO && it.touch_x <= PNL_X_HI &&
                   it.touch_y >= PNL_Y_LO && it.touch_y <= PNL_Y_HI;
          if (it.touch_pressure >= cfg.min_pressure) begin
            idle_cnt = '0;
            if (asleep) begin
              // A touch on a dark screen only wakes it
              asleep = 1'b0;
            end else if (in_mnt) begin
              case (mode)
                MODE_NORMAL: begin
                  mode        = MODE_CONFIRM;
                  confirm_cnt = '0;
                end
                MODE_CONFIRM: begin
                  mode   = MODE_ACTIVE;
                  lights = 1'b1;
                end
                default: begin
                  if (int'(cur_temp) >= int'(cfg.exit_min_temp)) mode = MODE_NORMAL;
                  else refused = 1'b1;
                end
              endcase
            end else if (mode != MODE_ACTIVE && in_pnl && !lights) begin
              ovr_run = 1'b1;
              ovr_cnt = '0;
              lights  = 1'b1;
            end
          end
        end
        default: ;
      endcase

      thr = int'(cfg.target_temp) - int'(cfg.heater_offset);
      r.heater_on       = (mode != MODE_ACTIVE) && (int'(cur_temp) < thr);
      r.filter_on       = (mode != MODE_ACTIVE);
      r.lights_on       = lights;
      r.mode            = mode;
      r.override_active = ovr_run;
      r.display_asleep  = asleep;
      r.exit_refused    = refused;
      r.temperature     = cur_temp;
      return r;
    endfunction

    // Note an accepted event and queue its expected status
    function void note_event(item_t it);
      case (it.command)
        CMD_TICK:   n_tick++;
        CMD_SAMPLE: n_sample++;
        CMD_TOUCH:  n_touch++;
        default:    n_unused++;
      endcase
      pending_status.push_back(predict_status(it));
    endfunction

    function int pending();
      return pending_status.size();
    endfunction

    task report(string what, longint exp_v, longint got_v);
      if (errors < 40)
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
      errors++;
    endtask

    // Compare a returned status item with the oldest expectation
    task check_status(result_t got);
      result_t exp;
      if (pending_status.size() == 0) begin
        report("status item with none pending", 0, 0);
      end else begin
        exp = pending_status.pop_front();
        checked++;
        if (got.heater_on !== exp.heater_on)
          report("heater_on", exp.heater_on, got.heater_on);
        if (got.filter_on !== exp.filter_on)
          report("filter_on", exp.filter_on, got.filter_on);
        if (got.lights_on !== exp.lights_on)
          report("lights_on", exp.lights_on, got.lights_on);
        if (got.mode !== exp.mode)
          report("mode", exp.mode, got.mode);
        if (got.override_active !== exp.override_active)
          report("override_active", exp.override_active, got.override_active);
        if (got.display_asleep !== exp.display_asleep)
          report("display_asleep", exp.display_asleep, got.display_asleep);
        if (got.exit_refused !== exp.exit_refused)
          report("exit_refused", exp.exit_refused, got.exit_refused);
        if (got.temperature !== exp.temperature)
          report("temperature", $signed(exp.temperature), $signed(got.temperature));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tmrc_in_if  ev_if ();
  tmrc_out_if st_if ();

  tank_mode_and_relay_controller u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (ev_if),
    .out_if  (st_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tank_status_checker chk;
  int                 n_settings;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watch both channels; check status before noting a new event
  always @(posedge clk_i) begin : watch
    result_t seen;
    item_t   took;
    if (rst_ni === 1'b1) begin
      if (st_if.valid === 1'b1 && st_if.ready === 1'b1) begin
        seen.heater_on       = st_if.heater_on;
        seen.filter_on       = st_if.filter_on;
        seen.lights_on       = st_if.lights_on;
        seen.mode            = st_if.mode;
        seen.override_active = st_if.override_active;
        seen.display_asleep  = st_if.display_asleep;
        seen.exit_refused    = st_if.exit_refused;
        seen.temperature     = st_if.temperature;
        chk.check_status(seen);
      end
      if (ev_if.valid === 1'b1 && ev_if.ready === 1'b1) begin
        took.command        = ev_if.command;
        took.temp_sample    = ev_if.temp_sample;
        took.touch_x        = ev_if.touch_x;
        took.touch_y        = ev_if.touch_y;
        took.touch_pressure = ev_if.touch_pressure;
        chk.note_event(took);
      end
    end
  end

  // Stall the status side in segments: open (twice as likely), coin flip, tight
  initial begin : stall_gen
    int left;
    int style;
    st_if.ready = 1'b0;
    left = 0;
    style = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(8, 60);
      end
      left--;
      case (style)
        0, 1:    st_if.ready <= 1'b1;
        2:       st_if.ready <= 1'($urandom_range(0, 1));
        default: st_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Present one event and hold it until accepted
  task automatic send_event(input item_t it);
    ev_if.valid          <= 1'b1;
    ev_if.command        <= it.command;
    ev_if.temp_sample    <= it.temp_sample;
    ev_if.touch_x        <= it.touch_x;
    ev_if.touch_y        <= it.touch_y;
    ev_if.touch_pressure <= it.touch_pressure;
    @(posedge clk_i);
    while (ev_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      ev_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every status item is back
  task automatic wait_results();
    ev_if.valid <= 1'b0;
    @(posedge clk_i);
    while (chk.pending() != 0) @(posedge clk_i);
  endtask

  // One APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    chk.set_reg(idx, val);
  endtask

  // Write all settings while the block is idle
  task automatic apply_cfg(input cfg_t c);
    wait_results();
    repeat (3) @(posedge clk_i);
    write_reg(REG_TARGET_TEMP,    DATA_W'(c.target_temp));
    write_reg(REG_HEATER_OFFSET,  DATA_W'(c.heater_offset));
    write_reg(REG_EXIT_MIN_TEMP,  DATA_W'(c.exit_min_temp));
    write_reg(REG_CONFIRM_LIMIT,  DATA_W'(c.confirm_limit));
    write_reg(REG_OVERRIDE_LIMIT, DATA_W'(c.override_limit));
    write_reg(REG_SLEEP_LIMIT,    DATA_W'(c.sleep_limit));
    write_reg(REG_MIN_PRESSURE,   DATA_W'(c.min_pressure));
    write_reg(REG_TEMP_DEADBAND,  DATA_W'(c.temp_deadband));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic item_t make_item(logic [CMD_W-1:0] cmd, int smp, int x, int y, int p);
    item_t it;
    it.command        = cmd;
    it.temp_sample    = smp[TEMP_W-1:0];
    it.touch_x        = x[PIX_W-1:0];
    it.touch_y        = y[PIX_W-1:0];
    it.touch_pressure = p[PRES_W-1:0];
    return it;
  endfunction

  // Pick a bound of a box edge, or the pixel just outside it
  function automatic logic [PIX_W-1:0] near_edge(logic [PIX_W-1:0] lo, logic [PIX_W-1:0] hi);
    logic [PIX_W-1:0] v;
    v = $urandom_range(0, 1) ? lo : hi;
    if ($urandom_range(0, 1)) v = (v == lo) ? v - 1'b1 : v + 1'b1;
    return v;
  endfunction

  function automatic cfg_t rand_cfg(input int lim_hi);
    cfg_t c;
    c.target_temp    = SP_W'($urandom_range(SET_MIN, SET_MAX));
    c.heater_offset  = OFS_W'($urandom_range(0, OFS_MAX));
    c.exit_min_temp  = SP_W'($urandom_range(SET_MIN, SET_MAX));
    c.confirm_limit  = CNT_W'($urandom_range(1, lim_hi));
    c.override_limit = CNT_W'($urandom_range(1, lim_hi));
    c.sleep_limit    = CNT_W'($urandom_range(1, lim_hi));
    c.min_pressure   = PRES_W'($urandom_range(0, PRES_MAX));
    c.temp_deadband  = OFS_W'($urandom_range(0, OFS_MAX));
    return c;
  endfunction

  function automatic cfg_t edge_cfg(input bit high);
    cfg_t c;
    c.target_temp    = SP_W'(high ? SET_MAX : SET_MIN);
    c.heater_offset  = OFS_W'(high ? OFS_MAX : 0);
    c.exit_min_temp  = SP_W'(high ? SET_MAX : SET_MIN);
    c.confirm_limit  = CNT_W'(high ? LIMIT_MAX : 1);
    c.override_limit = CNT_W'(high ? LIMIT_MAX : 1);
    c.sleep_limit    = CNT_W'(high ? LIMIT_MAX : 1);
    c.min_pressure   = PRES_W'(high ? PRES_MAX : 0);
    c.temp_deadband  = OFS_W'(high ? OFS_MAX : 0);
    return c;
  endfunction

  // Random event, weighted toward the button, the panel and the temperature
  // edges so that the mode and timer paths are reached often
  function automatic item_t make_event();
    item_t it;
    int    pick;
    int    t;
    int    mag;
    int    mp;
    it.command        = CMD_TICK;
    it.temp_sample    = TEMP_W'($urandom);
    it.touch_x        = PIX_W'($urandom);
    it.touch_y        = PIX_W'($urandom);
    it.touch_pressure = PRES_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.command = CMD_TICK;
    end else if (pick < 65) begin
      it.command = CMD_SAMPLE;
      case ($urandom_range(0, 3))
        0: t = $signed(it.temp_sample);
        1: t = ($urandom_range(0, 1) ? int'(TEMP_LOW) : int'(TEMP_HIGH)) +
               int'($urandom_range(0, 2)) - 1;
        2: begin
          mag = int'(chk.cfg.temp_deadband) + int'($urandom_range(0, 2)) - 1;
          t   = int'(chk.cur_temp) + ($urandom_range(0, 1) ? mag : -mag);
        end
        default: t = $urandom_range(SET_MIN, SET_MAX);
      endcase
      it.temp_sample = t[TEMP_W-1:0];
    end else if (pick < 95) begin
      it.command = CMD_TOUCH;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          it.touch_x = PIX_W'($urandom_range(MNT_X_LO, MNT_X_HI));
          it.touch_y = PIX_W'($urandom_range(MNT_Y_LO, MNT_Y_HI));
        end
        4: begin
          it.touch_x = near_edge(MNT_X_LO, MNT_X_HI);
          it.touch_y = near_edge(MNT_Y_LO, MNT_Y_HI);
        end
        5, 6, 7: begin
          it.touch_x = PIX_W'($urandom_range(PNL_X_LO, PNL_X_HI));
          it.touch_y = PIX_W'($urandom_range(PNL_Y_LO, PNL_Y_HI));
        end
        8: begin
          it.touch_x = near_edge(PNL_X_LO, PNL_X_HI);
          it.touch_y = near_edge(PNL_Y_LO, PNL_Y_HI);
        end
        default: ;
      endcase
      mp = int'(chk.cfg.min_pressure);
      case ($urandom_range(0, 9))
        0, 1:    it.touch_pressure = mp[PRES_W-1:0];
        2:       it.touch_pressure = (mp == 0) ? '0 : PRES_W'(mp - 1);
        3, 4:    ;
        default: it.touch_pressure = PRES_W'($urandom_range(mp, PRES_MAX));
      endcase
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  // Directed pass with short timers: override, sleep, wake, weak touch,
  // confirm timeout, entry to and exit from maintenance, refused exit,
  // sample limits and deadband, and the unused command
  task automatic run_directed();
    send_event(make_item(CMD_TOUCH, 0, 479, 279, 100));
    send_event(make_item(CMD_TOUCH, 0, 240, 40, 100));
    repeat (4) send_event(make_item(CMD_TICK, 0, 0, 0, 0));
    send_event(make_item(CMD_TOUCH, 0, 283, 5, 4095));
    send_event(make_item(CMD_TOUCH, 0, 282, 5, 4095));
    send_event(make_item(CMD_TOUCH, 0, 283, 5, 99));
    send_event(make_item(CMD_TOUCH, 0, 283, 5, 100));
    repeat (3) send_event(make_item(CMD_TICK, 0, 0, 0, 0));
    send_event(make_item(CMD_TOUCH, 0, 472, 34, 200));
    send_event(make_item(CMD_TOUCH, 0, 400, 20, 200));
    send_event(make_item(CMD_TOUCH, 0, 300, 100, 200));
    send_event(make_item(CMD_SAMPLE, 3200, 0, 0, 0));
    send_event(make_item(CMD_SAMPLE, 12000, 0, 0, 0));
    send_event(make_item(CMD_SAMPLE, 3201, 0, 0, 0));
    send_event(make_item(CMD_TOUCH, 0, 473, 35, 200));
    send_event(make_item(CMD_TOUCH, 0, 350, 15, 200));
    send_event(make_item(CMD_SAMPLE, 11999, 0, 0, 0));
    send_event(make_item(CMD_SAMPLE, 11994, 0, 0, 0));
    send_event(make_item(CMD_SAMPLE, -32768, 511, 511, 4095));
    send_event(make_item(CMD_TOUCH, 32767, 283, 34, 200));
    send_event(make_item(CMD_UNUSED, 32767, 511, 511, 4095));
  endtask

  // Random events in bursts with gaps; once, wait until all status is back
  task automatic run_random(input int count);
    int sent;
    int burst;
    int pause_at;
    sent     = 0;
    pause_at = $urandom_range(count / 4, 3 * count / 4);
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < count) begin
        send_event(make_event());
        sent++;
        burst--;
        if (sent == pause_at) wait_results();
      end
      hold_off($urandom_range(1, 6));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t c;
    chk        = new();
    n_settings = 1;
    ev_if.valid          = 1'b0;
    ev_if.command        = CMD_TICK;
    ev_if.temp_sample    = '0;
    ev_if.touch_x        = '0;
    ev_if.touch_y        = '0;
    ev_if.touch_pressure = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings
    send_event(make_item(CMD_SAMPLE, 7800, 0, 0, 0));
    send_event(make_item(CMD_TICK, 0, 0, 0, 0));

    // Directed pass with short timers
    c = edge_cfg(1'b0);
    c.target_temp    = SP_W'(7800);
    c.heater_offset  = OFS_W'(30);
    c.exit_min_temp  = SP_W'(7400);
    c.confirm_limit  = CNT_W'(3);
    c.override_limit = CNT_W'(4);
    c.sleep_limit    = CNT_W'(3);
    c.min_pressure   = PRES_W'(100);
    c.temp_deadband  = OFS_W'(5);
    apply_cfg(c);
    run_directed();

    // Random phases: mid-range, lowest, highest, mid-range again, then full-range
    apply_cfg(rand_cfg(50));
    run_random(170);
    apply_cfg(edge_cfg(1'b0));
    run_random(170);
    apply_cfg(edge_cfg(1'b1));
    run_random(170);
    apply_cfg(rand_cfg(20));
    run_random(170);
    apply_cfg(rand_cfg(LIMIT_MAX));
    run_random(170);

    wait_results();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d ticks, %0d samples, %0d touches, %0d unused commands over %0d settings",
             chk.n_tick, chk.n_sample, chk.n_touch, chk.n_unused, n_settings);
    $display("Checked %0d status items, %0d field errors", chk.checked, chk.errors);
    if (chk.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #400000;
    $display("Run stalled: %0d status items still pending", chk.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule
